// ===== rtl/core/cmfs_pkg.sv =====
// Shared types and constants for the cube map face select / texel address pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none

package cmfs_pkg;

	localparam int COMP_W    = 16;             // direction component width
	localparam int FRAC_W    = 16;             // Q0.16 coordinate fraction bits
	localparam int QUO_W     = FRAC_W + 1;     // coordinate width, 1.0 included
	localparam int DIV_STEPS = QUO_W;          // one quotient bit per stage
	localparam int SIZE_W    = 13;
	localparam int TEXEL_W   = 12;
	localparam int PROD_W    = SIZE_W + QUO_W;

	localparam logic [SIZE_W-1:0] FACE_SIZE_RST = 13'd512;
	localparam logic [QUO_W-1:0]  HALF_Q16      = 17'd32768;
	localparam logic [QUO_W-1:0]  ONE_Q16       = 17'd65536;

	localparam logic [2:0] FACE_NEG_Z = 3'd0;
	localparam logic [2:0] FACE_NEG_X = 3'd1;
	localparam logic [2:0] FACE_POS_Z = 3'd2;
	localparam logic [2:0] FACE_POS_X = 3'd3;
	localparam logic [2:0] FACE_POS_Y = 3'd4;
	localparam logic [2:0] FACE_NEG_Y = 3'd5;

	typedef struct packed {
		logic signed [COMP_W-1:0] dir_x;
		logic signed [COMP_W-1:0] dir_y;
		logic signed [COMP_W-1:0] dir_z;
	} vec_word_t;

	typedef struct packed {
		logic [2:0]         face;
		logic [QUO_W-1:0]   coord_u;
		logic [QUO_W-1:0]   coord_v;
		logic [TEXEL_W-1:0] texel_row;
		logic [TEXEL_W-1:0] texel_col;
		logic               zero_dir;
	} texel_word_t;

	// Divider pipeline word: both lanes share the major-axis divisor.
	typedef struct packed {
		logic [2:0]        face;
		logic              zero_dir;
		logic [COMP_W-1:0] divisor;
		logic [COMP_W-1:0] rem_u;
		logic [COMP_W-1:0] rem_v;
		logic [QUO_W-1:0]  feed_u;
		logic [QUO_W-1:0]  feed_v;
		logic [QUO_W-1:0]  quo_u;
		logic [QUO_W-1:0]  quo_v;
	} div_word_t;

endpackage

`default_nettype wire

// ===== rtl/core/cmfs_major_sel.sv =====
// Front stage: major axis pick, face code, minor-axis signs and divider setup.
// Depends on cmfs_pkg.
`default_nettype none

module cmfs_major_sel (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                vld_in,
	input  wire cmfs_pkg::vec_word_t vec,
	output logic                     vld_s1,
	output cmfs_pkg::div_word_t      word_s1
);
	import cmfs_pkg::*;

	logic [COMP_W-1:0]        ax, ay, az, amaj;
	logic signed [COMP_W:0]   x_e, y_e, z_e, su, sv;
	logic signed [COMP_W+1:0] num_u_w, num_v_w;
	logic [COMP_W:0]          num_u, num_v;
	logic [2:0]               face;
	logic                     is_zero;
	div_word_t                nxt;

	always_comb begin
		x_e = {vec.dir_x[COMP_W-1], vec.dir_x};
		y_e = {vec.dir_y[COMP_W-1], vec.dir_y};
		z_e = {vec.dir_z[COMP_W-1], vec.dir_z};
		// most negative value maps to 2^(W-1), which still fits unsigned
		ax = vec.dir_x[COMP_W-1] ? COMP_W'(~vec.dir_x + 1'b1) : $unsigned(vec.dir_x);
		ay = vec.dir_y[COMP_W-1] ? COMP_W'(~vec.dir_y + 1'b1) : $unsigned(vec.dir_y);
		az = vec.dir_z[COMP_W-1] ? COMP_W'(~vec.dir_z + 1'b1) : $unsigned(vec.dir_z);
		is_zero = (ax == '0) && (ay == '0) && (az == '0);

		if (az >= ax && az >= ay) begin
			face = vec.dir_z[COMP_W-1] ? FACE_NEG_Z : FACE_POS_Z;
			amaj = az;
			su   = vec.dir_z[COMP_W-1] ? -x_e : x_e;
			sv   = -y_e;
		end else if (ay >= ax) begin
			face = vec.dir_y[COMP_W-1] ? FACE_NEG_Y : FACE_POS_Y;
			amaj = ay;
			su   = x_e;
			sv   = vec.dir_y[COMP_W-1] ? -z_e : z_e;
		end else begin
			face = vec.dir_x[COMP_W-1] ? FACE_NEG_X : FACE_POS_X;
			amaj = ax;
			su   = vec.dir_x[COMP_W-1] ? z_e : -z_e;
			sv   = -y_e;
		end

		// zero vector: divide 1 by 1, which lands on the centre
		if (is_zero) begin
			amaj = COMP_W'(1);
			su   = '0;
			sv   = '0;
		end

		num_u_w = $signed({2'b00, amaj}) + $signed({su[COMP_W], su});
		num_v_w = $signed({2'b00, amaj}) + $signed({sv[COMP_W], sv});
		num_u   = num_u_w[COMP_W:0];
		num_v   = num_v_w[COMP_W:0];

		// quotient = (num << 15) / a: high part num >> 2, then num[1:0], then zeros
		nxt.face     = face;
		nxt.zero_dir = is_zero;
		nxt.divisor  = amaj;
		nxt.rem_u    = COMP_W'(num_u >> 2);
		nxt.rem_v    = COMP_W'(num_v >> 2);
		nxt.feed_u   = {num_u[1:0], (QUO_W-2)'(0)};
		nxt.feed_v   = {num_v[1:0], (QUO_W-2)'(0)};
		nxt.quo_u    = '0;
		nxt.quo_v    = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_s1 <= nxt;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/cmfs_div_step.sv =====
// One restoring-division stage: produces one quotient bit for both u and v lanes.
// Depends on cmfs_pkg.
`default_nettype none

module cmfs_div_step (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                vld_in,
	input  wire cmfs_pkg::div_word_t word_in,
	output logic                     vld_s1,
	output cmfs_pkg::div_word_t      word_s1
);
	import cmfs_pkg::*;

	logic [COMP_W:0] t_u, t_v, d_u, d_v, dvs;
	logic            ge_u, ge_v;
	div_word_t       nxt;

	always_comb begin
		dvs  = {1'b0, word_in.divisor};
		t_u  = {word_in.rem_u, word_in.feed_u[QUO_W-1]};
		t_v  = {word_in.rem_v, word_in.feed_v[QUO_W-1]};
		d_u  = t_u - dvs;
		d_v  = t_v - dvs;
		ge_u = t_u >= dvs;
		ge_v = t_v >= dvs;

		nxt        = word_in;
		// remainder stays below the divisor, so W bits hold it
		nxt.rem_u  = ge_u ? d_u[COMP_W-1:0] : t_u[COMP_W-1:0];
		nxt.rem_v  = ge_v ? d_v[COMP_W-1:0] : t_v[COMP_W-1:0];
		nxt.feed_u = {word_in.feed_u[QUO_W-2:0], 1'b0};
		nxt.feed_v = {word_in.feed_v[QUO_W-2:0], 1'b0};
		nxt.quo_u  = {word_in.quo_u[QUO_W-2:0], ge_u};
		nxt.quo_v  = {word_in.quo_v[QUO_W-2:0], ge_v};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_s1 <= nxt;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/cmfs_texel.sv =====
// Back end: face size clamp, size * coordinate multiply, then cap to size-1.
// Depends on cmfs_pkg.
`default_nettype none

module cmfs_texel #(
	parameter int MAX_FACE_SIZE = 4096
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en_mul,
	input  wire logic                          en_out,
	input  wire logic                          vld_in,
	input  wire cmfs_pkg::div_word_t           word_in,
	input  wire logic [cmfs_pkg::SIZE_W-1:0]   face_size,
	output logic                               vld_s1,
	output logic                               vld_s2,
	output cmfs_pkg::texel_word_t              word_s2
);
	import cmfs_pkg::*;

	localparam logic [SIZE_W+1:0] MaxSize = (SIZE_W+2)'(MAX_FACE_SIZE);
	localparam int                IDX_W   = PROD_W - FRAC_W;

	logic [SIZE_W+1:0]  sz_ext;
	logic [SIZE_W-1:0]  size_c;
	logic [2:0]         face_s1;
	logic               zero_s1;
	logic [QUO_W-1:0]   quo_u_s1, quo_v_s1;
	logic [SIZE_W-1:0]  size_s1;
	logic [PROD_W-1:0]  prod_u_s1, prod_v_s1;
	logic [SIZE_W-1:0]  lim;
	logic [IDX_W-1:0]   idx_u, idx_v, lim_e;
	texel_word_t        nxt;

	always_comb begin
		sz_ext = {2'b00, face_size};
		if (sz_ext == '0) begin
			sz_ext = (SIZE_W+2)'(1);
		end else if (sz_ext > MaxSize) begin
			sz_ext = MaxSize;
		end
		size_c = SIZE_W'(sz_ext);
	end

	always_ff @(posedge clk) begin
		if (en_mul) begin
			face_s1   <= word_in.face;
			zero_s1   <= word_in.zero_dir;
			quo_u_s1  <= word_in.quo_u;
			quo_v_s1  <= word_in.quo_v;
			size_s1   <= size_c;
			prod_u_s1 <= PROD_W'(size_c) * PROD_W'(word_in.quo_u);
			prod_v_s1 <= PROD_W'(size_c) * PROD_W'(word_in.quo_v);
		end
	end

	always_comb begin
		lim   = size_s1 - 1'b1;
		lim_e = IDX_W'(lim);
		idx_u = prod_u_s1[PROD_W-1:FRAC_W];
		idx_v = prod_v_s1[PROD_W-1:FRAC_W];
		// coordinate 1.0 lands one past the last texel: cap it
		if (idx_u > lim_e) begin
			idx_u = lim_e;
		end
		if (idx_v > lim_e) begin
			idx_v = lim_e;
		end
		nxt.face      = face_s1;
		nxt.coord_u   = quo_u_s1;
		nxt.coord_v   = quo_v_s1;
		nxt.texel_row = TEXEL_W'(idx_v);
		nxt.texel_col = TEXEL_W'(idx_u);
		nxt.zero_dir  = zero_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (en_mul) begin
				vld_s1 <= vld_in;
			end
			if (en_out) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			word_s2 <= nxt;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/cubemap_face_select_texel_address.sv =====
// Cube map face select and nearest-texel address pipeline.
// Stages: 1 select stage, 17 one-bit divider stages, multiply, cap/output.
// Throughput: one word per cycle while texel_stall is low; the restoring divider is fully unrolled into stages.
// Each stage advances whenever it is empty or its successor advances, so bubbles fill.
// Reset (arst_n low, asynchronous) empties the pipeline and sets face_size to 512.
`default_nettype none

module cubemap_face_select_texel_address #(
	parameter int MAX_FACE_SIZE = 4096
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         face_size_we,
	input  wire logic [cmfs_pkg::SIZE_W-1:0]  face_size_wdata,
	input  wire logic                         vec_valid,
	output logic                              vec_stall,
	input  wire cmfs_pkg::vec_word_t          vec,
	output logic                              texel_valid,
	input  wire logic                         texel_stall,
	output cmfs_pkg::texel_word_t             texel
);
	import cmfs_pkg::*;

	localparam int NSTG = DIV_STEPS + 3;

	logic [SIZE_W-1:0] face_size_q;
	logic [NSTG-1:0]   vld;
	logic [NSTG-1:0]   en;
	div_word_t         div_w [DIV_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_size_q <= FACE_SIZE_RST;
		end else if (face_size_we) begin
			face_size_q <= face_size_wdata;
		end
	end

	// advance a stage when it is empty or the one after it advances
	always_comb begin
		en[NSTG-1] = !vld[NSTG-1] || !texel_stall;
		for (int k = NSTG - 2; k >= 0; k--) begin
			en[k] = !vld[k] || en[k+1];
		end
	end

	assign vec_stall   = !en[0];
	assign texel_valid = vld[NSTG-1];

	cmfs_major_sel u_sel (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en[0]),
		.vld_in  (vec_valid),
		.vec     (vec),
		.vld_s1  (vld[0]),
		.word_s1 (div_w[0])
	);

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
		cmfs_div_step u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en[i+1]),
			.vld_in  (vld[i]),
			.word_in (div_w[i]),
			.vld_s1  (vld[i+1]),
			.word_s1 (div_w[i+1])
		);
	end

	cmfs_texel #(
		.MAX_FACE_SIZE (MAX_FACE_SIZE)
	) u_texel (
		.clk       (clk),
		.arst_n    (arst_n),
		.en_mul    (en[NSTG-2]),
		.en_out    (en[NSTG-1]),
		.vld_in    (vld[DIV_STEPS]),
		.word_in   (div_w[DIV_STEPS]),
		.face_size (face_size_q),
		.vld_s1    (vld[NSTG-2]),
		.vld_s2    (vld[NSTG-1]),
		.word_s2   (texel)
	);

endmodule

`default_nettype wire

// ===== rtl/core/cmfs_checker.sv =====
// Port-level checks for the cube map texel address block, bound to its top level.
// Depends on cmfs_pkg and cubemap_face_select_texel_address.
`default_nettype none

module cmfs_checker (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  texel_valid,
	input wire logic                  texel_stall,
	input wire cmfs_pkg::texel_word_t texel
);
	import cmfs_pkg::*;

	// hold a stalled word
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		texel_valid && texel_stall |=> texel_valid && $stable(texel))
		else $error("stalled output word changed or dropped");

	a_face_range: assert property (@(posedge clk) disable iff (!arst_n)
		texel_valid |-> texel.face <= FACE_NEG_Y)
		else $error("face code out of range");

	a_coord_range: assert property (@(posedge clk) disable iff (!arst_n)
		texel_valid |-> texel.coord_u <= ONE_Q16 && texel.coord_v <= ONE_Q16)
		else $error("face coordinate above 1.0");

	a_zero_centre: assert property (@(posedge clk) disable iff (!arst_n)
		texel_valid && texel.zero_dir |->
			texel.face == FACE_POS_Z && texel.coord_u == HALF_Q16 &&
			texel.coord_v == HALF_Q16)
		else $error("zero direction not mapped to the centre");

endmodule

bind cubemap_face_select_texel_address cmfs_checker u_cmfs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.texel_valid (texel_valid),
	.texel_stall (texel_stall),
	.texel       (texel)
);

`default_nettype wire
